[rtl/core/ofr_pkg.sv]
// ----------------------------------------------------------------------------
// Optical frame receiver package
// Shared types, register indexes, reset values and status codes.
// ----------------------------------------------------------------------------
package ofr_pkg;

  localparam int DATA_BITS_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LIT_LIMIT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT    = 3'd4;

  localparam logic [11:0] LIT_LIMIT_RST       = 12'd250;
  localparam logic [7:0]  SAMPLE_INTERVAL_RST = 8'd10;
  localparam logic [9:0]  BIT_PERIOD_RST      = 10'd100;
  localparam logic [15:0] PREAMBLE_LENGTH_RST = 16'd500;
  localparam logic [15:0] IDLE_TIMEOUT_RST    = 16'd750;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_FRAME   = 2'd1;
  localparam logic [1:0] ST_NO_STOP = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [11:0] lit_limit;
    logic [7:0]  sample_interval;
    logic [9:0]  bit_period;
    logic [15:0] preamble_length;
    logic [15:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] frame_id;
  } res_t;

endpackage

[rtl/core/optical_frame_receiver.sv]
// ----------------------------------------------------------------------------
// Optical frame receiver
// Recovers short frames from one light-sensor sample per tick.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     sensor_sample
//   result    out_valid / out_ready   status, frame_id
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each request passes an input register and then a result register.
// One request is accepted per cycle while results are taken.
// A stalled result holds the result register and then the input register.
// Reset restores the register defaults and clears all receive state.
// Configuration writes complete in the cycle they are presented.
// ----------------------------------------------------------------------------
module optical_frame_receiver import ofr_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           sensor_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [3:0]            frame_id,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  res_t        res;
  logic        s1_valid;
  logic [11:0] s1_sample;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lit_limit       <= LIT_LIMIT_RST;
      cfg.sample_interval <= SAMPLE_INTERVAL_RST;
      cfg.bit_period      <= BIT_PERIOD_RST;
      cfg.preamble_length <= PREAMBLE_LENGTH_RST;
      cfg.idle_timeout    <= IDLE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIT_LIMIT:       cfg.lit_limit       <= cfg_data[11:0];
        REG_SAMPLE_INTERVAL: cfg.sample_interval <= cfg_data[7:0];
        REG_BIT_PERIOD:      cfg.bit_period      <= cfg_data[9:0];
        REG_PREAMBLE_LENGTH: cfg.preamble_length <= cfg_data;
        REG_IDLE_TIMEOUT:    cfg.idle_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sensor_sample;
    end
  end

  ofr_core #(
    .DATA_BITS(DATA_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .sample (s1_sample),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status   <= res.status;
      frame_id <= res.frame_id;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_sample))
    else $error("stalled input register lost its request");

  a_id_only_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FRAME |-> frame_id == 4'd0)
    else $error("frame id set without a valid frame");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed request produced no result");
`endif

endmodule

[rtl/core/ofr_core.sv]
// ----------------------------------------------------------------------------
// Optical frame receiver core
// Holds the receive state and decodes one sensor sample per step.
// ----------------------------------------------------------------------------
module ofr_core import ofr_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        step,
  input  logic [11:0] sample,
  output res_t        res
);

  localparam int BitCntW = $clog2(DATA_BITS + 1);

  logic                 rx_mode, rx_mode_next;
  logic [7:0]           sample_phase, sample_phase_next;
  logic [9:0]           bit_phase, bit_phase_next;
  logic [9:0]           sync_phase, sync_phase_next;
  logic [15:0]          dark_time, dark_time_next;
  logic [15:0]          bright_time, bright_time_next;
  logic [BitCntW-1:0]   bit_count, bit_count_next;
  logic [DATA_BITS-1:0] data_shift, data_shift_next;

  logic                 light;
  logic [16:0]          dark_sum;
  logic [16:0]          bright_sum;
  logic [15:0]          dark_sat;
  logic [15:0]          bright_sat;
  logic [8:0]           sample_inc;
  logic [10:0]          bit_inc;
  logic [DATA_BITS:0]   shifted;
  logic [DATA_BITS+3:0] id_ext;

  assign light      = sample < cfg.lit_limit;
  assign dark_sum   = {1'b0, dark_time} + {9'b0, cfg.sample_interval};
  assign bright_sum = {1'b0, bright_time} + {9'b0, cfg.sample_interval};
  assign dark_sat   = dark_sum[16] ? 16'hFFFF : dark_sum[15:0];
  assign bright_sat = bright_sum[16] ? 16'hFFFF : bright_sum[15:0];
  assign sample_inc = {1'b0, sample_phase} + 9'd1;
  assign bit_inc    = {1'b0, bit_phase} + 11'd1;
  assign shifted    = {data_shift, light};
  assign id_ext     = {4'b0, data_shift};

  always_comb begin
    rx_mode_next     = rx_mode;
    sync_phase_next  = sync_phase;
    dark_time_next   = dark_time;
    bright_time_next = bright_time;
    bit_count_next   = bit_count;
    data_shift_next  = data_shift;
    res.status       = ST_NONE;
    res.frame_id     = 4'd0;

    if (!rx_mode) begin
      if (sample_phase == 8'd0) begin
        priority if (light) begin
          bright_time_next = 16'd0;
          dark_time_next   = dark_sat;
        end else if (bright_time >= cfg.idle_timeout) begin
          bright_time_next = 16'd0;
          res.status       = ST_TIMEOUT;
        end else begin
          if (dark_time >= cfg.preamble_length) begin
            rx_mode_next = 1'b1;
          end
          dark_time_next   = 16'd0;
          bright_time_next = bright_sat;
          sync_phase_next  = bit_phase;
        end
      end
    end else if (bit_phase == sync_phase) begin
      if (bit_count == BitCntW'(DATA_BITS)) begin
        bit_count_next = '0;
        rx_mode_next   = 1'b0;
        dark_time_next = {6'b0, cfg.bit_period};
        if (light) begin
          res.status   = ST_FRAME;
          res.frame_id = id_ext[3:0];
        end else begin
          res.status = ST_NO_STOP;
        end
      end else begin
        data_shift_next = shifted[DATA_BITS-1:0];
        bit_count_next  = bit_count + BitCntW'(1);
      end
    end

    sample_phase_next = (sample_inc >= {1'b0, cfg.sample_interval}) ? 8'd0 : sample_inc[7:0];
    bit_phase_next    = (bit_inc >= {1'b0, cfg.bit_period}) ? 10'd0 : bit_inc[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode      <= 1'b0;
      sample_phase <= 8'd0;
      bit_phase    <= 10'd0;
      sync_phase   <= 10'd0;
      dark_time    <= 16'd0;
      bright_time  <= 16'd0;
      bit_count    <= '0;
      data_shift   <= '0;
    end else if (step) begin
      rx_mode      <= rx_mode_next;
      sample_phase <= sample_phase_next;
      bit_phase    <= bit_phase_next;
      sync_phase   <= sync_phase_next;
      dark_time    <= dark_time_next;
      bright_time  <= bright_time_next;
      bit_count    <= bit_count_next;
      data_shift   <= data_shift_next;
    end
  end

`ifndef SYNTHESIS
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !rx_mode |-> bit_count == '0)
    else $error("bit count not clear during preamble search");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BitCntW'(DATA_BITS))
    else $error("bit count beyond stop bit");

  a_frame_exit: assert property (@(posedge clk) disable iff (rst)
    step && (res.status == ST_FRAME || res.status == ST_NO_STOP) |=> !rx_mode)
    else $error("receiver stayed in data mode after frame end");
`endif

endmodule

[verif/tb_optical_frame_receiver.sv]
// ----------------------------------------------------------------------------
// Optical frame receiver testbench
// Drives light-sensor samples, register writes and result back-pressure into
// the receiver and checks every result against a cycle-free model of the
// preamble search, bit sampling and frame decoding. Stimulus is mostly
// well-formed preambles and frames with random content, mixed with noise and
// corrupted frames, under several register settings including the extremes.
// Long runs of register writes drive the dark and bright timers into
// saturation.
// ----------------------------------------------------------------------------
module tb_optical_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import ofr_pkg::*;

  localparam int STALL_LIMIT = 2000;

  class frame_scoreboard;
    cfg_t                     regs;
    logic                     receiving;
    logic [7:0]               sample_phase;
    logic [9:0]               bit_phase;
    logic [9:0]               sync_phase;
    logic [15:0]              dark_time;
    logic [15:0]              bright_time;
    logic [2:0]               bit_count;
    logic [DATA_BITS_DEF-1:0] data_shift;
    res_t                     expected_q[$];
    int                       errors;
    int                       n_frames;
    int                       n_no_stop;
    int                       n_timeouts;

    function new();
      regs.lit_limit       = LIT_LIMIT_RST;
      regs.sample_interval = SAMPLE_INTERVAL_RST;
      regs.bit_period      = BIT_PERIOD_RST;
      regs.preamble_length = PREAMBLE_LENGTH_RST;
      regs.idle_timeout    = IDLE_TIMEOUT_RST;
      receiving    = 1'b0;
      sample_phase = '0;
      bit_phase    = '0;
      sync_phase   = '0;
      dark_time    = '0;
      bright_time  = '0;
      bit_count    = '0;
      data_shift   = '0;
      errors       = 0;
      n_frames     = 0;
      n_no_stop    = 0;
      n_timeouts   = 0;
    endfunction

    function logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LIT_LIMIT:       regs.lit_limit       = val[11:0];
        REG_SAMPLE_INTERVAL: regs.sample_interval = val[7:0];
        REG_BIT_PERIOD:      regs.bit_period      = val[9:0];
        REG_PREAMBLE_LENGTH: regs.preamble_length = val;
        REG_IDLE_TIMEOUT:    regs.idle_timeout    = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [11:0] smp);
      logic is_lit;
      res_t r;
      is_lit     = smp < regs.lit_limit;
      r.status   = ST_NONE;
      r.frame_id = '0;
      if (!receiving) begin
        if (sample_phase == 0) begin
          if (is_lit) begin
            bright_time = '0;
            dark_time   = sat_add(dark_time, 16'(regs.sample_interval));
          end else if (bright_time >= regs.idle_timeout) begin
            bright_time = '0;
            r.status    = ST_TIMEOUT;
          end else begin
            if (dark_time >= regs.preamble_length) receiving = 1'b1;
            dark_time   = '0;
            bright_time = sat_add(bright_time, 16'(regs.sample_interval));
            sync_phase  = bit_phase;
          end
        end
      end else if (bit_phase == sync_phase) begin
        if (int'(bit_count) < DATA_BITS_DEF) begin
          data_shift = {data_shift[DATA_BITS_DEF-2:0], is_lit};
        end
        bit_count = bit_count + 3'd1;
        if (int'(bit_count) >= DATA_BITS_DEF + 1) begin
          bit_count = '0;
          receiving = 1'b0;
          dark_time = 16'(regs.bit_period);
          if (is_lit) begin
            r.status   = ST_FRAME;
            r.frame_id = 4'(data_shift);
          end else begin
            r.status = ST_NO_STOP;
          end
        end
      end
      sample_phase = (int'(sample_phase) + 1 >= int'(regs.sample_interval)) ? 8'd0 :
                     sample_phase + 8'd1;
      bit_phase    = (int'(bit_phase) + 1 >= int'(regs.bit_period)) ? 10'd0 :
                     bit_phase + 10'd1;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [3:0] id);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d frame_id %0d", $time, st, id);
        return;
      end
      exp_r = expected_q.pop_front();
      if (st !== exp_r.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, exp_r.status, st);
      end
      if (id !== exp_r.frame_id) begin
        errors++;
        $display("%0t: frame_id mismatch: expected %0d, actual %0d", $time, exp_r.frame_id,
                 id);
      end
      case (exp_r.status)
        ST_FRAME:   n_frames++;
        ST_NO_STOP: n_no_stop++;
        ST_TIMEOUT: n_timeouts++;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [11:0]           sensor_sample = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [1:0]            status;
  logic [3:0]            frame_id;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  frame_scoreboard sb = new();
  logic [11:0]     stim_q[$];
  int              tx_idle_pct  = 7;
  int              rx_idle_pct  = 71;
  int              n_samples    = 0;
  int              n_writes     = 0;
  int              stall_cycles = 0;

  optical_frame_receiver i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sensor_sample (sensor_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .frame_id      (frame_id),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(status, frame_id);
      if (in_valid && in_ready) begin
        sb.note_sample(sensor_sample);
        n_samples++;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        n_writes++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic play_samples();
    for (int i = 0; i < stim_q.size(); i++) begin
      @(negedge clk);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid      <= 1'b1;
      sensor_sample <= stim_q[i];
      do @(posedge clk); while (!in_ready);
      if ($urandom_range(149, 0) == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_cfg(cfg_t c);
    write_reg(REG_LIT_LIMIT, 16'(c.lit_limit));
    write_reg(REG_SAMPLE_INTERVAL, 16'(c.sample_interval));
    write_reg(REG_BIT_PERIOD, 16'(c.bit_period));
    write_reg(REG_PREAMBLE_LENGTH, c.preamble_length);
    write_reg(REG_IDLE_TIMEOUT, c.idle_timeout);
  endtask

  function automatic logic [11:0] level_val(logic lit);
    int thr;
    thr = sb.regs.lit_limit;
    if (lit && thr > 0) return 12'($urandom_range(thr - 1, 0));
    return 12'($urandom_range(4095, thr));
  endfunction

  function automatic void push_level(logic lit, int ticks, int flip_pm);
    logic l;
    for (int i = 0; i < ticks; i++) begin
      l = lit ^ ($urandom_range(999, 0) < flip_pm);
      stim_q.push_back(level_val(l));
    end
  endfunction

  function automatic int period_ticks();
    return (sb.regs.bit_period == 0) ? 1 : int'(sb.regs.bit_period);
  endfunction

  function automatic void push_frame(logic [3:0] id, logic stop_lit, int flip_pm);
    int per;
    int ivl;
    int pre;
    per = period_ticks();
    ivl = (sb.regs.sample_interval == 0) ? 1 : int'(sb.regs.sample_interval);
    pre = (sb.regs.preamble_length > 300) ? 300 : int'(sb.regs.preamble_length);
    push_level(1'b1, pre + ivl + $urandom_range(3, 0), flip_pm);
    push_level(1'b0, per, flip_pm);
    for (int b = 3; b >= 0; b--) push_level(id[b], per, flip_pm);
    push_level(stop_lit, per, flip_pm);
  endfunction

  function automatic cfg_t pick_cfg(int k);
    cfg_t c;
    c.bit_period      = 10'($urandom_range(12, 1));
    c.sample_interval = 8'($urandom_range(c.bit_period, 1));
    c.lit_limit       = 12'($urandom_range(3900, 150));
    c.preamble_length = 16'($urandom_range(40, 0));
    c.idle_timeout    = 16'($urandom_range(90, 1));
    case (k)
      3:  c.lit_limit       = 12'd0;
      5:  c.lit_limit       = 12'd4095;
      9:  c.idle_timeout    = 16'd0;
      11: c.preamble_length = 16'hFFFF;
      13: c.idle_timeout    = 16'hFFFF;
      default: ;
    endcase
    return c;
  endfunction

  task automatic run_batch(int n_items);
    while (stim_q.size() < n_items) begin
      if ($urandom_range(99, 0) < 20) begin
        repeat ($urandom_range(20, 1)) stim_q.push_back(12'($urandom_range(4095, 0)));
      end else begin
        push_frame(4'($urandom_range(15, 0)), $urandom_range(99, 0) < 85,
                   ($urandom_range(99, 0) < 25) ? 30 : 0);
      end
    end
    push_level(1'b1, 5 * period_ticks() + 1, 0);
    play_samples();
  endtask

  task automatic run_saturation();
    cfg_t c;
    c.lit_limit       = 12'd2048;
    c.sample_interval = 8'd1;
    c.bit_period      = 10'd1;
    c.preamble_length = 16'hFFFF;
    c.idle_timeout    = 16'hFFFF;
    apply_cfg(c);
    push_level(1'b1, 8, 0);
    play_samples();
    // Each round samples once with a long interval and then idles one tick with
    // an interval of one, so the timer grows by 254 for every two requests.
    repeat (262) begin
      write_reg(REG_SAMPLE_INTERVAL, 16'd254);
      push_level(1'b1, 1, 0);
      play_samples();
      write_reg(REG_SAMPLE_INTERVAL, 16'd1);
      push_level(1'b1, 1, 0);
      play_samples();
    end
    write_reg(REG_SAMPLE_INTERVAL, 16'd254);
    push_level(1'b0, 1, 0);
    for (int b = 0; b < 4; b++) push_level(1'($urandom_range(1, 0)), 1, 0);
    push_level(1'b1, 1, 0);
    play_samples();
    write_reg(REG_SAMPLE_INTERVAL, 16'd1);
    push_level(1'b0, 1, 0);
    play_samples();
    repeat (262) begin
      write_reg(REG_SAMPLE_INTERVAL, 16'd254);
      push_level(1'b0, 1, 0);
      play_samples();
      write_reg(REG_SAMPLE_INTERVAL, 16'd1);
      push_level(1'b0, 1, 0);
      play_samples();
    end
  endtask

  initial begin
    cfg_t c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    stim_q = '{12'd0, 12'd4095, 12'd249, 12'd250, 12'hAAA, 12'h555};
    play_samples();

    c.lit_limit       = 12'd2048;
    c.sample_interval = 8'd1;
    c.bit_period      = 10'd1;
    c.preamble_length = 16'd0;
    c.idle_timeout    = 16'hFFFF;
    apply_cfg(c);
    stim_q = '{12'd1, 12'd2048, 12'd2047, 12'd4095, 12'd0, 12'd2048, 12'd1};
    play_samples();
    write_reg(REG_IDLE_TIMEOUT, 16'd0);
    stim_q = '{12'd4095};
    play_samples();
    write_reg(REG_SAMPLE_INTERVAL, 16'd0);
    write_reg(REG_BIT_PERIOD, 16'd0);
    write_reg(REG_IDLE_TIMEOUT, 16'hFFFF);
    stim_q = '{12'd4095, 12'd2048, 12'd2047, 12'd4095, 12'd0, 12'd2048};
    play_samples();

    for (int k = 0; k < 7; k++) begin
      apply_cfg(pick_cfg(k));
      run_batch(24);
    end

    tx_idle_pct = 71;
    rx_idle_pct = 7;
    for (int k = 7; k < 14; k++) begin
      apply_cfg(pick_cfg(k));
      run_batch(24);
    end
    c.lit_limit       = 12'd2000;
    c.sample_interval = 8'd255;
    c.bit_period      = 10'd1023;
    c.preamble_length = 16'd300;
    c.idle_timeout    = 16'hFFFF;
    apply_cfg(c);
    push_level(1'b1, 8, 0);
    play_samples();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_saturation();
    for (int k = 14; k < 16; k++) begin
      apply_cfg(pick_cfg(k));
      run_batch(24);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d sensor samples and %0d register writes, with both timers saturated.",
             n_samples, n_writes);
    $display("Checked %0d good frames, %0d missing stop bits and %0d timeouts.",
             sb.n_frames, sb.n_no_stop, sb.n_timeouts);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
